// ----- hw/rtl/mamd_pkg.sv -----
`default_nettype none
package mamd_pkg;

	localparam int WINDOW_DEFAULT     = 64;
	localparam int FIFO_DEPTH_DEFAULT = 8;
	localparam int AXES               = 3;
	localparam int SAMPLE_W           = 16;
	localparam int SUM_W              = 23;
	localparam int ABS_W              = 22;
	localparam int RECIP_SHIFT        = 28;
	localparam int RECIP_W            = 29;
	localparam int MEAN_W             = 18;
	localparam int TICK_W             = 32;

	localparam logic [1:0] FUNC_SAMPLE = 2'd0;
	localparam logic [1:0] FUNC_END    = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;

	localparam logic [SAMPLE_W-1:0] THRESH_RESET = 16'd400;

	// index 0 is x, in the lowest bits
	typedef logic [AXES-1:0][SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic              changed;
		logic [TICK_W-1:0] ticks;
		logic              act;
	} result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mamd_ram.sv -----
`default_nettype none
module mamd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/moving_average_motion_detector.sv -----
`default_nettype none
// channel  dir  tdata                                      tuser
// s_axis   in   [15:0] accel_x [31:16] accel_y [47:32] accel_z  [1:0] func
// m_axis   out  [0] activity_state [32:1] elapsed_ticks       [0] state_changed
// cfg      in   cfg_wdata = deviation_threshold, written when cfg_we is high
//
// one item per cycle while tready is high; its result passes s1, s2 and s3 into the fifo
// the window ram is read at accept and written back in the next cycle, the sum
// recurrence closes in that one stage; the mean and compare follow in stages 2 and 3
// window entries read as zero until the ring pointer first wraps, no clearing pass
// results queue in a FIFO_DEPTH-entry fifo; tready drops while FIFO_DEPTH items
// are taken and not yet delivered
module moving_average_motion_detector import mamd_pkg::*; #(
	parameter int WINDOW     = WINDOW_DEFAULT,
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [SAMPLE_W-1:0] cfg_wdata,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [47:0]         s_axis_tdata,   // accel_x, accel_y, accel_z
	input  logic [1:0]          s_axis_tuser,   // func
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [39:0]         m_axis_tdata,   // activity_state, elapsed_ticks, zero pad
	output logic [0:0]          m_axis_tuser    // state_changed
);

	localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((longint'(1) << RECIP_SHIFT) / WINDOW + 1);
	localparam int OCC_W = $clog2(FIFO_DEPTH + 1);
	localparam int FP_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam logic [FP_W-1:0] FP_LAST = FP_W'(FIFO_DEPTH - 1);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(FIFO_DEPTH);

	logic signed [SAMPLE_W-1:0] thresh_q;

	logic       accept, pop;
	logic       in_is_samp;
	sample_t    in_samp;
	logic [PTR_W-1:0] ptr_q;
	logic       filled_q;
	logic [OCC_W-1:0] occ_q;

	// stage 1: ram data returns, sum update, write back
	logic             v_s1;
	logic [1:0]       func_s1;
	sample_t          samp_s1;
	logic [PTR_W-1:0] slot_s1;
	logic             filled_s1;
	logic             fwd_s1;
	sample_t          fwd_data_s1;
	logic             samp_s1_is;
	sample_t          rdata;
	sample_t          old_s1;
	logic signed [SUM_W-1:0] sum_q [AXES];
	logic signed [SUM_W-1:0] sum_nxt [AXES];

	// stage 2: mean by reciprocal multiply
	logic             v_s2;
	logic [1:0]       func_s2;
	sample_t          samp_s2;
	logic signed [SUM_W-1:0] sum_s2 [AXES];
	logic signed [MEAN_W-1:0] mean_nxt [AXES];

	// stage 3: compare and activity update
	logic             v_s3;
	logic [1:0]       func_s3;
	sample_t          samp_s3;
	logic signed [MEAN_W-1:0] mean_s3 [AXES];
	logic [AXES-1:0]  hit;
	logic             flag_q, act_q;
	logic [TICK_W-1:0] tick_q;
	logic             flag_nxt, act_nxt, changed;
	logic [TICK_W-1:0] tick_nxt;
	result_t          res;

	result_t          fifo_q [FIFO_DEPTH];
	logic [FP_W-1:0]  head_q, tail_q;
	logic [OCC_W-1:0] cnt_q;
	result_t          out_res;

	assign accept     = s_axis_tvalid && s_axis_tready;
	assign pop        = m_axis_tvalid && m_axis_tready;
	assign in_samp    = sample_t'(s_axis_tdata);
	assign in_is_samp = (s_axis_tuser == FUNC_SAMPLE) || (s_axis_tuser == FUNC_END);
	assign samp_s1_is = (func_s1 == FUNC_SAMPLE) || (func_s1 == FUNC_END);
	assign s_axis_tready = (occ_q != OCC_FULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			filled_q <= 1'b0;
			occ_q    <= '0;
		end else begin
			if (accept && in_is_samp) begin
				ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
				if (ptr_q == PTR_LAST) begin
					filled_q <= 1'b1;
				end
			end
			occ_q <= occ_q + OCC_W'(accept) - OCC_W'(pop);
		end
	end

	mamd_ram #(
		.WIDTH ($bits(sample_t)),
		.DEPTH (WINDOW)
	) u_win (
		.clk   (clk),
		.we    (v_s1 && samp_s1_is),
		.waddr (slot_s1),
		.wdata (samp_s1),
		.re    (accept && in_is_samp),
		.raddr (ptr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// read and write of the same entry in one cycle only happens with a one-entry window
	always_ff @(posedge clk) begin
		func_s1     <= s_axis_tuser;
		samp_s1     <= in_samp;
		slot_s1     <= ptr_q;
		filled_s1   <= filled_q;
		fwd_s1      <= v_s1 && samp_s1_is && (slot_s1 == ptr_q);
		fwd_data_s1 <= samp_s1;
	end

	assign old_s1 = fwd_s1 ? fwd_data_s1 : (filled_s1 ? rdata : '0);

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			sum_nxt[a] = sum_q[a] - SUM_W'($signed(old_s1[a])) + SUM_W'($signed(samp_s1[a]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= '0;
			end
		end else if (v_s1 && samp_s1_is) begin
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= sum_nxt[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		func_s2 <= func_s1;
		samp_s2 <= samp_s1;
		for (int a = 0; a < AXES; a++) begin
			sum_s2[a] <= sum_q[a];
		end
	end

	// truncating divide by the window length: |sum| times a rounded-up reciprocal
	always_comb begin
		logic                      neg;
		logic [ABS_W-1:0]          absv;
		logic [ABS_W+RECIP_W-1:0]  prod;
		logic [MEAN_W-2:0]         quo;
		for (int a = 0; a < AXES; a++) begin
			neg  = sum_s2[a][SUM_W-1];
			absv = neg ? ABS_W'(-sum_s2[a]) : ABS_W'(sum_s2[a]);
			prod = (ABS_W+RECIP_W)'(absv) * (ABS_W+RECIP_W)'(RECIP);
			quo  = prod[RECIP_SHIFT +: MEAN_W-1];
			mean_nxt[a] = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		end
	end

	always_ff @(posedge clk) begin
		func_s3 <= func_s2;
		samp_s3 <= samp_s2;
		for (int a = 0; a < AXES; a++) begin
			mean_s3[a] <= mean_nxt[a];
		end
	end

	always_comb begin
		logic signed [MEAN_W-1:0] diff;
		logic signed [MEAN_W-1:0] thr;
		thr = MEAN_W'(thresh_q);
		for (int a = 0; a < AXES; a++) begin
			diff   = MEAN_W'($signed(samp_s3[a])) - mean_s3[a];
			hit[a] = (diff > thr) || (-diff > thr);
		end
	end

	always_comb begin
		flag_nxt = flag_q;
		act_nxt  = act_q;
		tick_nxt = tick_q;
		changed  = 1'b0;
		case (func_s3)
			FUNC_SAMPLE: begin
				flag_nxt = flag_q || (|hit);
			end
			FUNC_END: begin
				act_nxt  = flag_q || (|hit);
				flag_nxt = 1'b0;
				if (act_nxt != act_q) begin
					changed  = 1'b1;
					tick_nxt = '0;
				end
			end
			FUNC_TICK: begin
				if (tick_q != '1) begin
					tick_nxt = tick_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
			act_q  <= 1'b1;
			tick_q <= '0;
		end else if (v_s3) begin
			flag_q <= flag_nxt;
			act_q  <= act_nxt;
			tick_q <= tick_nxt;
		end
	end

	assign res.changed = changed;
	assign res.ticks   = tick_nxt;
	assign res.act     = act_nxt;

	// result queue; the credit count in occ_q keeps it from overflowing
	always_ff @(posedge clk) begin
		if (v_s3) begin
			fifo_q[tail_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (v_s3) begin
				tail_q <= (tail_q == FP_LAST) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= (head_q == FP_LAST) ? '0 : head_q + 1'b1;
			end
			cnt_q <= cnt_q + OCC_W'(v_s3) - OCC_W'(pop);
		end
	end

	assign out_res       = fifo_q[head_q];
	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = {7'd0, out_res.ticks, out_res.act};
	assign m_axis_tuser  = out_res.changed;

`ifndef SYNTH
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_FULL) else $error("credit count above queue depth");

	a_cnt_le_occ: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= occ_q) else $error("queue holds more results than items in flight");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == OCC_FULL) |-> !v_s3) else $error("result pushed into full queue");

	a_change_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[32:1] == '0))
		else $error("state change without tick clear");
`endif

endmodule
`default_nettype wire
